>>> rtl/tpi_pkg.sv
// Shared types and constants for the turtle path interpreter.
package tpi_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] SYM_F     = 8'h46;
    localparam logic [7:0] SYM_G     = 8'h47;
    localparam logic [7:0] SYM_PUSH  = 8'h5B;
    localparam logic [7:0] SYM_POP   = 8'h5D;
    localparam logic [7:0] SYM_LEFT  = 8'h2B;
    localparam logic [7:0] SYM_RIGHT = 8'h2D;

    localparam logic signed [15:0] COS_RST     = 16'sd15826;
    localparam logic signed [15:0] SIN_RST     = 16'sd4241;
    localparam logic signed [15:0] START_X_RST = 16'sd0;
    localparam logic signed [15:0] START_Y_RST = 16'sd16384;

    localparam logic [1:0] REG_COS     = 2'd0;
    localparam logic [1:0] REG_SIN     = 2'd1;
    localparam logic [1:0] REG_START_X = 2'd2;
    localparam logic [1:0] REG_START_Y = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_STEP,
        OP_PUSH,
        OP_POP,
        OP_LEFT,
        OP_RIGHT
    } t_op;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_POP_EMPTY = 2'd1,
        FAULT_PUSH_FULL = 2'd2
    } t_fault;

    typedef struct packed {
        t_op        op;
        logic [9:0] tag;
        logic       restart;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic signed [15:0] start_dir_x;
        logic signed [15:0] start_dir_y;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [9:0]         tag;
        logic               seg_end;
        t_fault             fault;
    } t_vertex;

endpackage

>>> rtl/tpi_front.sv
// Front end: accepts symbol words, decodes them and queues commands.
module tpi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_symbol,
    input  logic [9:0]    i_iteration_tag,
    input  logic          i_restart,
    output logic          o_cmd_valid,
    output tpi_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);
    import tpi_pkg::*;

    t_op        dec_op;
    t_cmd       in_cmd;
    logic       push;
    logic       pop;
    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        unique case (i_symbol)
            SYM_F, SYM_G: dec_op = OP_STEP;
            SYM_PUSH:     dec_op = OP_PUSH;
            SYM_POP:      dec_op = OP_POP;
            SYM_LEFT:     dec_op = OP_LEFT;
            SYM_RIGHT:    dec_op = OP_RIGHT;
            default:      dec_op = OP_NOP;
        endcase
    end

    assign in_cmd      = '{op: dec_op, tag: i_iteration_tag, restart: i_restart};
    assign o_in_stall  = (r_cnt == 2'd2);
    // ignored symbols without restart have no effect: taken but not queued
    assign push        = i_in_valid && !o_in_stall && ((dec_op != OP_NOP) || i_restart);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_cmd;
        end
    end

endmodule

>>> rtl/tpi_back.sv
// Back end: turtle state, branch stack and result queue.
module tpi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpi_pkg::t_cfg    i_cfg,
    input  logic             i_cmd_valid,
    input  tpi_pkg::t_cmd    i_cmd,
    output logic             o_cmd_take,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tpi_pkg::t_vertex o_vertex
);
    import tpi_pkg::*;

    localparam logic signed [35:0] HEAD_MAX = 36'sd131071;
    localparam logic signed [35:0] HEAD_MIN = -36'sd131072;
    localparam logic signed [32:0] POS_MAX  = 33'sd2147483647;
    localparam logic signed [32:0] POS_MIN  = -33'sd2147483648;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [17:0] hx;
        logic signed [17:0] hy;
    } t_stk;

    logic signed [31:0] r_px, r_py, n_px, n_py;
    logic signed [17:0] r_hx, r_hy, n_hx, n_hy;
    logic [STK_CW-1:0]  r_cnt, n_cnt;
    t_stk               r_stk [STACK_DEPTH];

    logic signed [31:0] eff_px, eff_py;
    logic signed [17:0] eff_hx, eff_hy;
    logic [STK_CW-1:0]  eff_cnt;
    logic [STK_CW-1:0]  pop_idx;
    logic               full, empty;
    logic [1:0]         need;
    logic [2:0]         free;

    logic signed [33:0] p_cx, p_sy, p_sx, p_cy;
    logic signed [35:0] nx_sum, ny_sum, nx_r, ny_r;
    logic signed [17:0] rot_x, rot_y;
    logic signed [32:0] sx_sum, sy_sum;
    logic signed [31:0] step_x, step_y;

    t_vertex            w0, w1;
    t_vertex            r_oq [4];
    logic [1:0]         r_owr, r_ord;
    logic [2:0]         r_ocnt;
    logic               opop;

    // restart is applied before the symbol
    always_comb begin
        eff_px  = i_cmd.restart ? 32'sd0 : r_px;
        eff_py  = i_cmd.restart ? 32'sd0 : r_py;
        eff_hx  = i_cmd.restart ? 18'(i_cfg.start_dir_x) : r_hx;
        eff_hy  = i_cmd.restart ? 18'(i_cfg.start_dir_y) : r_hy;
        eff_cnt = i_cmd.restart ? '0 : r_cnt;
        full    = (eff_cnt >= STK_CW'(STACK_DEPTH));
        empty   = (eff_cnt == '0);
        pop_idx = eff_cnt - STK_CW'(1);
    end

    always_comb begin
        case (i_cmd.op)
            OP_STEP: need = 2'd2;
            OP_PUSH: need = full ? 2'd1 : 2'd0;
            OP_POP:  need = empty ? 2'd1 : 2'd0;
            default: need = 2'd0;
        endcase
    end

    assign free       = 3'd4 - r_ocnt;
    assign o_cmd_take = i_cmd_valid && (free >= {1'b0, need});

    // rotation: four independent products, round to nearest, clamp to 18 bits
    always_comb begin
        p_cx = $signed(i_cfg.cos_angle) * eff_hx;
        p_sy = $signed(i_cfg.sin_angle) * eff_hy;
        p_sx = $signed(i_cfg.sin_angle) * eff_hx;
        p_cy = $signed(i_cfg.cos_angle) * eff_hy;
        if (i_cmd.op == OP_LEFT) begin
            nx_sum = 36'(p_cx) - 36'(p_sy);
            ny_sum = 36'(p_sx) + 36'(p_cy);
        end else begin
            nx_sum = 36'(p_cx) + 36'(p_sy);
            ny_sum = 36'(p_cy) - 36'(p_sx);
        end
        nx_r = (nx_sum + 36'sd8192) >>> 14;
        ny_r = (ny_sum + 36'sd8192) >>> 14;
        if (nx_r > HEAD_MAX) begin
            rot_x = HEAD_MAX[17:0];
        end else if (nx_r < HEAD_MIN) begin
            rot_x = HEAD_MIN[17:0];
        end else begin
            rot_x = nx_r[17:0];
        end
        if (ny_r > HEAD_MAX) begin
            rot_y = HEAD_MAX[17:0];
        end else if (ny_r < HEAD_MIN) begin
            rot_y = HEAD_MIN[17:0];
        end else begin
            rot_y = ny_r[17:0];
        end
    end

    // saturating step
    always_comb begin
        sx_sum = 33'(eff_px) + 33'(eff_hx);
        sy_sum = 33'(eff_py) + 33'(eff_hy);
        if (sx_sum > POS_MAX) begin
            step_x = POS_MAX[31:0];
        end else if (sx_sum < POS_MIN) begin
            step_x = POS_MIN[31:0];
        end else begin
            step_x = sx_sum[31:0];
        end
        if (sy_sum > POS_MAX) begin
            step_y = POS_MAX[31:0];
        end else if (sy_sum < POS_MIN) begin
            step_y = POS_MIN[31:0];
        end else begin
            step_y = sy_sum[31:0];
        end
    end

    always_comb begin
        n_px  = r_px;
        n_py  = r_py;
        n_hx  = r_hx;
        n_hy  = r_hy;
        n_cnt = r_cnt;
        if (o_cmd_take) begin
            n_px  = eff_px;
            n_py  = eff_py;
            n_hx  = eff_hx;
            n_hy  = eff_hy;
            n_cnt = eff_cnt;
            case (i_cmd.op)
                OP_STEP: begin
                    n_px = step_x;
                    n_py = step_y;
                end
                OP_PUSH: begin
                    if (!full) begin
                        n_cnt = eff_cnt + STK_CW'(1);
                    end
                end
                OP_POP: begin
                    if (!empty) begin
                        n_cnt = pop_idx;
                        n_px  = r_stk[pop_idx[STK_AW-1:0]].x;
                        n_py  = r_stk[pop_idx[STK_AW-1:0]].y;
                        n_hx  = r_stk[pop_idx[STK_AW-1:0]].hx;
                        n_hy  = r_stk[pop_idx[STK_AW-1:0]].hy;
                    end
                end
                OP_LEFT, OP_RIGHT: begin
                    n_hx = rot_x;
                    n_hy = rot_y;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= '0;
            r_py  <= '0;
            r_hx  <= 18'(START_X_RST);
            r_hy  <= 18'(START_Y_RST);
            r_cnt <= '0;
        end else begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_hx  <= n_hx;
            r_hy  <= n_hy;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take && (i_cmd.op == OP_PUSH) && !full) begin
            r_stk[eff_cnt[STK_AW-1:0]] <= '{x: eff_px, y: eff_py, hx: eff_hx, hy: eff_hy};
        end
    end

    // result words: first is the current position, second the stepped one
    always_comb begin
        w0.x       = eff_px;
        w0.y       = eff_py;
        w0.tag     = i_cmd.tag;
        w0.seg_end = 1'b0;
        if (i_cmd.op == OP_STEP) begin
            w0.fault = FAULT_NONE;
        end else if (i_cmd.op == OP_PUSH) begin
            w0.fault = FAULT_PUSH_FULL;
        end else begin
            w0.fault = FAULT_POP_EMPTY;
        end
        w1.x       = step_x;
        w1.y       = step_y;
        w1.tag     = i_cmd.tag;
        w1.seg_end = 1'b1;
        w1.fault   = FAULT_NONE;
    end

    assign o_out_valid = (r_ocnt != 3'd0);
    assign opop        = o_out_valid && !i_out_stall;
    assign o_vertex    = r_oq[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (o_cmd_take) begin
                r_owr <= r_owr + need;
            end
            if (opop) begin
                r_ord <= r_ord + 2'd1;
            end
            r_ocnt <= r_ocnt + (o_cmd_take ? {1'b0, need} : 3'd0) - {2'b00, opop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take && (need != 2'd0)) begin
            r_oq[r_owr] <= w0;
        end
        if (o_cmd_take && (need == 2'd2)) begin
            r_oq[r_owr + 2'd1] <= w1;
        end
    end

endmodule

>>> rtl/turtle_path_interpreter.sv
// Top level: APB register file, front decoder and back end executor.
//
// Symbol words enter on the input channel (i_in_valid / o_in_stall); a word
// is taken at an edge where valid is high and stall is low. Vertex words
// leave on the output channel (o_out_valid / i_out_stall) the same way.
// The front decodes each symbol into a command and holds up to two in a
// queue; the back runs one command per cycle while the output queue has
// room, against the turtle state and the branch stack, and writes its
// results into a four-word output queue. Throughput: one symbol per cycle
// when nothing stalls; a draw symbol puts out two vertices, so the output
// port limits runs of draw symbols. The back holds a command until the
// output queue has room for all of its results; when the receiver stalls,
// the queues fill and o_in_stall rises. Reset (synchronous, active low)
// loads the register defaults, puts the turtle at the origin with the
// start heading and empties the stack and both queues. The user is to write
// registers over APB only while the block is idle; it is not enforced.
module turtle_path_interpreter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_symbol,
    input  logic [9:0]         i_iteration_tag,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_vertex_x,
    output logic signed [31:0] o_vertex_y,
    output logic [9:0]         o_vertex_tag,
    output logic               o_segment_end,
    output logic [1:0]         o_fault
);
    import tpi_pkg::*;

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_take;
    t_vertex vtx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_angle   <= COS_RST;
            r_cfg.sin_angle   <= SIN_RST;
            r_cfg.start_dir_x <= START_X_RST;
            r_cfg.start_dir_y <= START_Y_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_COS:     r_cfg.cos_angle   <= pwdata[15:0];
                REG_SIN:     r_cfg.sin_angle   <= pwdata[15:0];
                REG_START_X: r_cfg.start_dir_x <= pwdata[15:0];
                REG_START_Y: r_cfg.start_dir_y <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COS:     prdata = 32'(r_cfg.cos_angle);
            REG_SIN:     prdata = 32'(r_cfg.sin_angle);
            REG_START_X: prdata = 32'(r_cfg.start_dir_x);
            REG_START_Y: prdata = 32'(r_cfg.start_dir_y);
            default:     prdata = '0;
        endcase
    end

    tpi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_symbol        (i_symbol),
        .i_iteration_tag (i_iteration_tag),
        .i_restart       (i_restart),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_take      (cmd_take)
    );

    tpi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_vertex    (vtx)
    );

    assign o_vertex_x    = vtx.x;
    assign o_vertex_y    = vtx.y;
    assign o_vertex_tag  = vtx.tag;
    assign o_segment_end = vtx.seg_end;
    assign o_fault       = vtx.fault;

endmodule
